// ----- rtl/length_prefixed_frame_parser_defines.svh -----
// assertion macros shared by the frame parser checker
`ifndef LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_PARSER_DEFINES_SVH

// same-cycle implication, disabled during reset
`define LPFP_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define LPFP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lpfp_pkg.sv -----
// types and constants of the length prefixed frame parser
package lpfp_pkg;

   localparam logic [7:0] START_BYTE = 8'hFC;
   localparam logic [7:0] FIXED_A    = 8'h01;
   localparam logic [7:0] FIXED_B    = 8'h30;

   localparam int LEN_W = 5;
   localparam int IDX_W = 4;

   // header byte position, start byte counted as zero
   localparam logic [2:0] HDR_TYPE    = 3'd1;
   localparam logic [2:0] HDR_FIXED_A = 3'd2;
   localparam logic [2:0] HDR_FIXED_B = 3'd3;
   localparam logic [2:0] HDR_LEN     = 3'd4;

   typedef enum logic [5:0] {
      ST_HUNT   = 6'b000001,
      ST_HEADER = 6'b000010,
      ST_DATA   = 6'b000100,
      ST_CHECK  = 6'b001000,
      ST_FETCH  = 6'b010000,
      ST_EMIT   = 6'b100000
   } state_type;

   typedef struct packed {
      logic start;
      logic hdr_take;
      logic data_take;
      logic chk_take;
      logic out_err;
      logic out_empty;
      logic out_byte;
   } cmd_type;

   typedef struct packed {
      logic out_free;
      logic is_start;
      logic hdr_last;
      logic hdr_ok;
      logic len_zero;
      logic data_last;
      logic sum_ok;
      logic empty_frame;
      logic idx_last;
   } sts_type;

   typedef struct packed {
      logic             status;
      logic [7:0]       frame_type;
      logic [LEN_W-1:0] payload_len;
      logic             has_byte;
      logic [IDX_W-1:0] byte_index;
      logic [7:0]       payload_byte;
      logic [7:0]       check_byte;
      logic             last;
   } rsp_data_type;

endpackage

// ----- rtl/lpfp_if.sv -----
// valid/ready channel interfaces of the frame parser
interface lpfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface lpfp_rsp_if;
   logic       valid;
   logic       ready;
   logic       status;
   logic [7:0] frame_type;
   logic [4:0] payload_len;
   logic       has_byte;
   logic [3:0] byte_index;
   logic [7:0] payload_byte;
   logic [7:0] check_byte;
   logic       last;

   modport source (output valid, output status, output frame_type, output payload_len,
                   output has_byte, output byte_index, output payload_byte,
                   output check_byte, output last, input ready);
   modport sink   (input valid, input status, input frame_type, input payload_len,
                   input has_byte, input byte_index, input payload_byte,
                   input check_byte, input last, output ready);
endinterface

// ----- rtl/length_prefixed_frame_parser.sv -----
// top level of the length prefixed frame parser
//
// req_if carries one received link word per handshake (rx_byte). the parser
// hunts for start word 0xFC, takes type, two fixed words (0x01, 0x30) and a
// length, stores up to MAX_PAYLOAD payload words and checks the closing
// checksum word against 0xFC minus the 8-bit sum of all earlier words.
// rsp_if returns one word per payload byte of a good frame (last on the
// final one), a single marker for an empty frame, or a single error word.
// header and payload words are taken one per cycle while the output
// register can take a result. an error or empty-frame result shows on
// rsp_if in the cycle after the word that caused it. for a good frame,
// each payload result takes a read of the payload ram and then a load of
// the output register; the next read starts once that result is loaded.
// req_if.ready is low while the payload drains and whenever the output
// register holds a result that rsp_if does not take; a stalled receiver
// therefore holds the parser without losing a result.
// reset (synchronous) returns the parser to hunting with no result pending.
module length_prefixed_frame_parser import lpfp_pkg::*; #(
   parameter int MAX_PAYLOAD = 16
) (
   input logic       clock,
   input logic       reset,
   lpfp_req_if.sink  req_if,
   lpfp_rsp_if.source rsp_if
);

   cmd_type      cmd;
   sts_type      sts;
   rsp_data_type rsp_data;

   lpfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lpfp_datapath #(
      .MAX_PAYLOAD (MAX_PAYLOAD)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_if.rx_byte),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_ready (rsp_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_if.status       = rsp_data.status;
   assign rsp_if.frame_type   = rsp_data.frame_type;
   assign rsp_if.payload_len  = rsp_data.payload_len;
   assign rsp_if.has_byte     = rsp_data.has_byte;
   assign rsp_if.byte_index   = rsp_data.byte_index;
   assign rsp_if.payload_byte = rsp_data.payload_byte;
   assign rsp_if.check_byte   = rsp_data.check_byte;
   assign rsp_if.last         = rsp_data.last;

endmodule

// ----- rtl/lpfp_ram.sv -----
// generic single write port ram with registered read
module lpfp_ram #(
   parameter int  WIDTH = 8,
   parameter int  DEPTH = 16,
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lpfp_ctrl.sv -----
// frame parser controller state machine
module lpfp_ctrl import lpfp_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;
   logic      fire;

   assign req_ready = sts.out_free && !(state_ff inside {ST_FETCH, ST_EMIT});
   assign fire      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_HUNT: begin
            if (fire && sts.is_start) begin
               cmd.start = 1'b1;
               state_in  = ST_HEADER;
            end
         end
         ST_HEADER: begin
            if (fire) begin
               cmd.hdr_take = 1'b1;
               if (sts.hdr_last) begin
                  if (!sts.hdr_ok) begin
                     cmd.out_err = 1'b1;
                     state_in    = ST_HUNT;
                  end else if (sts.len_zero) begin
                     state_in = ST_CHECK;
                  end else begin
                     state_in = ST_DATA;
                  end
               end
            end
         end
         ST_DATA: begin
            if (fire) begin
               cmd.data_take = 1'b1;
               if (sts.data_last) begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            if (fire) begin
               if (!sts.sum_ok) begin
                  cmd.out_err = 1'b1;
                  state_in    = ST_HUNT;
               end else if (sts.empty_frame) begin
                  cmd.out_empty = 1'b1;
                  state_in      = ST_HUNT;
               end else begin
                  cmd.chk_take = 1'b1;
                  state_in     = ST_FETCH;
               end
            end
         end
         ST_FETCH: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (sts.out_free) begin
               cmd.out_byte = 1'b1;
               state_in     = sts.idx_last ? ST_HUNT : ST_FETCH;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ----- rtl/lpfp_datapath.sv -----
// frame parser datapath: header capture, checksum, payload store, output register
module lpfp_datapath import lpfp_pkg::*; #(
   parameter int MAX_PAYLOAD = 16
) (
   input  logic         clock,
   input  logic         reset,
   input  logic [7:0]   rx_byte,
   input  cmd_type      cmd,
   output sts_type      sts,
   input  logic         rsp_ready,
   output logic         rsp_valid,
   output rsp_data_type rsp_data
);

   localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
   localparam int         CW      = $clog2(MAX_PAYLOAD + 1);
   localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

   logic [2:0]    hdr_cnt_ff, hdr_cnt_in;
   logic          fixed_ok_ff, fixed_ok_in;
   logic [7:0]    type_ff, type_in;
   logic [CW-1:0] len_ff, len_in;
   logic [CW-1:0] data_cnt_ff, data_cnt_in;
   logic [7:0]    sum_ff, sum_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [7:0]    check_ff, check_in;
   logic          out_vld_ff, out_vld_in;
   rsp_data_type  out_ff, out_in;
   logic [7:0]    rd_data;

   lpfp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_PAYLOAD)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.data_take),
      .wr_addr (data_cnt_ff[AW-1:0]),
      .wr_data (rx_byte),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   always_comb begin
      sts.out_free    = !out_vld_ff || rsp_ready;
      sts.is_start    = (rx_byte == START_BYTE);
      sts.hdr_last    = (hdr_cnt_ff == HDR_LEN);
      sts.hdr_ok      = fixed_ok_ff && (rx_byte <= MAX_LEN);
      sts.len_zero    = (rx_byte == 8'd0);
      sts.data_last   = (CW'(data_cnt_ff + 1'b1) == len_ff);
      sts.sum_ok      = (rx_byte == 8'(START_BYTE - sum_ff));
      sts.empty_frame = (len_ff == '0);
      sts.idx_last    = (CW'({1'b0, idx_ff} + 1'b1) == len_ff);
   end

   always_comb begin
      hdr_cnt_in  = hdr_cnt_ff;
      fixed_ok_in = fixed_ok_ff;
      type_in     = type_ff;
      len_in      = len_ff;
      data_cnt_in = data_cnt_ff;
      sum_in      = sum_ff;
      idx_in      = idx_ff;
      check_in    = check_ff;
      out_vld_in  = out_vld_ff && !rsp_ready;
      out_in      = out_ff;

      if (cmd.start) begin
         hdr_cnt_in  = HDR_TYPE;
         fixed_ok_in = 1'b0;
         sum_in      = START_BYTE;
         data_cnt_in = '0;
      end

      if (cmd.hdr_take) begin
         sum_in     = sum_ff + rx_byte;
         hdr_cnt_in = hdr_cnt_ff + 3'd1;
         case (hdr_cnt_ff)
            HDR_TYPE:    type_in     = rx_byte;
            HDR_FIXED_A: fixed_ok_in = (rx_byte == FIXED_A);
            HDR_FIXED_B: fixed_ok_in = fixed_ok_ff && (rx_byte == FIXED_B);
            default:     len_in      = CW'(rx_byte);
         endcase
      end

      if (cmd.data_take) begin
         sum_in      = sum_ff + rx_byte;
         data_cnt_in = data_cnt_ff + 1'b1;
      end

      if (cmd.chk_take) begin
         check_in = rx_byte;
         idx_in   = '0;
      end

      if (cmd.out_err) begin
         out_vld_in = 1'b1;
         out_in     = '0;
         out_in.status = 1'b1;
         out_in.last   = 1'b1;
      end

      if (cmd.out_empty) begin
         out_vld_in            = 1'b1;
         out_in                = '0;
         out_in.frame_type     = type_ff;
         out_in.check_byte     = rx_byte;
         out_in.last           = 1'b1;
      end

      if (cmd.out_byte) begin
         out_vld_in          = 1'b1;
         out_in.status       = 1'b0;
         out_in.frame_type   = type_ff;
         out_in.payload_len  = LEN_W'(len_ff);
         out_in.has_byte     = 1'b1;
         out_in.byte_index   = IDX_W'(idx_ff);
         out_in.payload_byte = rd_data;
         out_in.check_byte   = check_ff;
         out_in.last         = sts.idx_last;
         idx_in              = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff  <= '0;
         data_cnt_ff <= '0;
         idx_ff      <= '0;
         out_vld_ff  <= 1'b0;
      end else begin
         hdr_cnt_ff  <= hdr_cnt_in;
         data_cnt_ff <= data_cnt_in;
         idx_ff      <= idx_in;
         out_vld_ff  <= out_vld_in;
      end
      fixed_ok_ff <= fixed_ok_in;
      type_ff     <= type_in;
      len_ff      <= len_in;
      sum_ff      <= sum_in;
      check_ff    <= check_in;
      out_ff      <= out_in;
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_data  = out_ff;

endmodule

// ----- rtl/lpfp_checker.sv -----
// port-level checker of the frame parser and its bind
`include "length_prefixed_frame_parser_defines.svh"

module lpfp_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       status,
   input logic [4:0] payload_len,
   input logic       has_byte,
   input logic [3:0] byte_index,
   input logic [7:0] payload_byte,
   input logic       last
);

   // a stalled result holds its word
   `LPFP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(status) && $stable(byte_index) && $stable(payload_byte) && $stable(last), "stalled result changed")

   // an error result is a single empty word
   `LPFP_ASSERT_SAME(a_err_single, rsp_valid && status, last && !has_byte && (payload_len == 5'd0), "error result not a lone word")

   // a result without a payload byte closes its run
   `LPFP_ASSERT_SAME(a_empty_last, rsp_valid && !has_byte, last, "empty result not last")

   // no new word is taken while a payload run drains
   `LPFP_ASSERT_SAME(a_drain_block, rsp_valid && has_byte && !last, !req_ready, "input taken during drain")

endmodule

bind length_prefixed_frame_parser lpfp_checker u_lpfp_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_if.ready),
   .rsp_valid    (rsp_if.valid),
   .rsp_ready    (rsp_if.ready),
   .status       (rsp_if.status),
   .payload_len  (rsp_if.payload_len),
   .has_byte     (rsp_if.has_byte),
   .byte_index   (rsp_if.byte_index),
   .payload_byte (rsp_if.payload_byte),
   .last         (rsp_if.last)
);

// ----- tb/length_prefixed_frame_parser_test.sv -----
// self-checking testbench of the length prefixed frame parser
module length_prefixed_frame_parser_test;
   timeunit 1ns;
   timeprecision 1ps;
   import lpfp_pkg::*;

   localparam int MAX_PAYLOAD  = 16;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int HOLD_CYCLES  = 300;

   typedef enum logic [1:0] {HUNTING, IN_HEADER, IN_DATA, AT_CHECK} parse_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   lpfp_req_if req_if();
   lpfp_rsp_if rsp_if();

   length_prefixed_frame_parser #(.MAX_PAYLOAD(MAX_PAYLOAD)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // parser state as seen from the link side
   parse_phase_type phase = HUNTING;
   logic [2:0] hdr_count = 3'd0;
   logic       fixed_ok = 1'b0;
   logic [7:0] type_q = 8'h00;
   logic [7:0] len_q = 8'h00;
   logic [4:0] data_count = 5'd0;
   logic [7:0] byte_sum = 8'h00;
   logic [7:0] payload_mem [MAX_PAYLOAD];

   rsp_data_type frame_results_due[$];
   int  failures = 0;
   int  parsed_words = 0;
   int  hold_left = 0;
   bit  sender_gaps = 1'b1;
   bit  receiver_gaps = 1'b1;

   function automatic void restart_hunt();
      phase = HUNTING;
      hdr_count = 3'd0;
      fixed_ok = 1'b0;
      type_q = 8'h00;
      len_q = 8'h00;
      data_count = 5'd0;
      byte_sum = 8'h00;
   endfunction

   function automatic void push_frame_error();
      rsp_data_type r;
      r = '0;
      r.status = 1'b1;
      r.last = 1'b1;
      frame_results_due.push_back(r);
      restart_hunt();
   endfunction

   function automatic void parse_rx_word(input logic [7:0] b);
      rsp_data_type r;
      logic [7:0] want;
      case (phase)
         HUNTING: begin
            if (b == START_BYTE) begin
               phase = IN_HEADER;
               hdr_count = 3'd1;
               fixed_ok = 1'b0;
               byte_sum = START_BYTE;
            end
         end
         IN_HEADER: begin
            byte_sum = byte_sum + b;
            case (hdr_count)
               HDR_TYPE:    type_q = b;
               HDR_FIXED_A: fixed_ok = (b == FIXED_A);
               HDR_FIXED_B: fixed_ok = fixed_ok && (b == FIXED_B);
               default:     len_q = b;
            endcase
            if (hdr_count != HDR_LEN) begin
               hdr_count = hdr_count + 3'd1;
            end else if (!fixed_ok || len_q > MAX_PAYLOAD) begin
               push_frame_error();
            end else begin
               data_count = 5'd0;
               phase = (len_q == 8'h00) ? AT_CHECK : IN_DATA;
            end
         end
         IN_DATA: begin
            payload_mem[data_count[3:0]] = b;
            byte_sum = byte_sum + b;
            data_count = data_count + 5'd1;
            if (data_count >= len_q) phase = AT_CHECK;
         end
         default: begin
            want = START_BYTE - byte_sum;
            if (b != want) begin
               push_frame_error();
            end else begin
               for (int k = 0; k < ((len_q == 8'h00) ? 1 : int'(len_q)); k++) begin
                  r = '0;
                  r.frame_type = type_q;
                  r.payload_len = len_q[4:0];
                  r.has_byte = (len_q != 8'h00);
                  r.byte_index = k[3:0];
                  r.payload_byte = (len_q != 8'h00) ? payload_mem[k[3:0]] : 8'h00;
                  r.check_byte = b;
                  r.last = (len_q == 8'h00) || (k + 1 == int'(len_q));
                  frame_results_due.push_back(r);
               end
               restart_hunt();
            end
         end
      endcase
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic void check_result();
      rsp_data_type want;
      if (frame_results_due.size() == 0) begin
         $error("result word with none pending");
         failures++;
      end else begin
         want = frame_results_due.pop_front();
         check_field("status", 8'(want.status), 8'(rsp_if.status));
         check_field("frame_type", want.frame_type, rsp_if.frame_type);
         check_field("payload_len", 8'(want.payload_len), 8'(rsp_if.payload_len));
         check_field("has_byte", 8'(want.has_byte), 8'(rsp_if.has_byte));
         check_field("byte_index", 8'(want.byte_index), 8'(rsp_if.byte_index));
         check_field("payload_byte", want.payload_byte, rsp_if.payload_byte);
         check_field("check_byte", want.check_byte, rsp_if.check_byte);
         check_field("last", 8'(want.last), 8'(rsp_if.last));
      end
   endfunction

   function automatic logic [7:0] rand_byte();
      logic [7:0] v;
      case ($urandom_range(9))
         0:       v = 8'h00;
         1:       v = 8'hFF;
         2:       v = START_BYTE;
         default: v = 8'($urandom_range(255));
      endcase
      return v;
   endfunction

   task automatic send_word(input logic [7:0] b);
      while (sender_gaps && $urandom_range(99) < 30) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.rx_byte <= b;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      if (phase != HUNTING || b == START_BYTE) parsed_words++;
      parse_rx_word(b);
   endtask

   task automatic send_frame(input logic [7:0] ftype, input logic [7:0] fa,
                             input logic [7:0] fb, input logic [7:0] len,
                             input bit bad_sum);
      logic [7:0] sum, b, flip;
      send_word(START_BYTE);
      send_word(ftype);
      send_word(fa);
      send_word(fb);
      send_word(len);
      if (fa != FIXED_A || fb != FIXED_B || len > MAX_PAYLOAD) return;
      sum = START_BYTE + ftype + fa + fb + len;
      for (int k = 0; k < int'(len); k++) begin
         b = rand_byte();
         sum = sum + b;
         send_word(b);
      end
      flip = bad_sum ? 8'($urandom_range(1, 255)) : 8'h00;
      send_word((START_BYTE - sum) ^ flip);
   endtask

   task automatic send_random_frame();
      int pick;
      logic [7:0] len, ftype, flip;
      pick = $urandom_range(99);
      len = ($urandom_range(9) == 0) ? 8'(MAX_PAYLOAD) : 8'($urandom_range(6));
      ftype = rand_byte();
      flip = 8'($urandom_range(1, 255));
      if (pick < 65) begin
         send_frame(ftype, FIXED_A, FIXED_B, len, 1'b0);
      end else if (pick < 73) begin
         repeat ($urandom_range(1, 3)) send_word(rand_byte());
      end else if (pick < 78) begin
         send_frame(ftype, FIXED_A ^ flip, FIXED_B, len, 1'b0);
      end else if (pick < 83) begin
         send_frame(ftype, FIXED_A, FIXED_B ^ flip, len, 1'b0);
      end else if (pick < 88) begin
         send_frame(ftype, FIXED_A, FIXED_B, 8'($urandom_range(MAX_PAYLOAD + 1, 255)), 1'b0);
      end else if (pick < 95) begin
         send_frame(ftype, FIXED_A, FIXED_B, len, 1'b1);
      end else begin
         // cut-off header, the next frame runs into it
         send_word(START_BYTE);
         repeat ($urandom_range(1, 3)) send_word(rand_byte());
      end
   endtask

   task automatic test_directed_frames();
      send_word(8'h00);
      send_word(8'hFF);
      send_word(8'hFD);
      send_frame(8'h00, FIXED_A, FIXED_B, 8'd0, 1'b0);
      send_frame(8'hFF, FIXED_A, FIXED_B, 8'(MAX_PAYLOAD), 1'b0);
      send_frame(8'h81, FIXED_A, FIXED_B, 8'd1, 1'b0);
      send_frame(8'h3C, 8'h00, FIXED_B, 8'd4, 1'b0);
      send_frame(8'h3C, FIXED_A, 8'h31, 8'd4, 1'b0);
      send_frame(8'h3C, 8'hFE, 8'hCF, 8'd2, 1'b0);
      send_frame(8'h42, FIXED_A, FIXED_B, 8'(MAX_PAYLOAD + 1), 1'b0);
      send_frame(8'h42, FIXED_A, FIXED_B, 8'hFF, 1'b0);
      // length word equal to the start word must not open a new frame
      send_frame(8'h42, FIXED_A, FIXED_B, START_BYTE, 1'b0);
      send_frame(8'h17, FIXED_A, FIXED_B, 8'd0, 1'b1);
      send_frame(8'h17, FIXED_A, FIXED_B, 8'd5, 1'b1);
      send_frame(START_BYTE, FIXED_A, FIXED_B, 8'd3, 1'b0);
   endtask

   task automatic test_random_frames();
      int first;
      first = parsed_words;
      while (parsed_words - first < 15) send_random_frame();
   endtask

   task automatic test_back_to_back();
      sender_gaps = 1'b0;
      receiver_gaps = 1'b0;
      send_frame(8'h5A, FIXED_A, FIXED_B, 8'(MAX_PAYLOAD), 1'b0);
      send_frame(8'hA5, FIXED_A, FIXED_B, 8'd0, 1'b0);
      repeat (4) send_random_frame();
      sender_gaps = 1'b1;
      receiver_gaps = 1'b1;
   endtask

   task automatic test_receiver_hold_off();
      hold_left = HOLD_CYCLES;
      repeat (2) send_frame(rand_byte(), FIXED_A, FIXED_B, 8'(MAX_PAYLOAD), 1'b0);
      send_random_frame();
   endtask

   // result side: check each accepted word, then pick next ready
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) check_result();
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= !(receiver_gaps && $urandom_range(99) < 30);
         end
      end
   end

   initial begin
      int stalled;
      stalled = 0;
      while (stalled < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
             (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1))
            stalled = 0;
         else
            stalled++;
      end
      $display("Test completed with failures");
      $finish;
   end

   initial begin
      req_if.valid <= 1'b0;
      req_if.rx_byte <= 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      test_directed_frames();
      test_random_frames();
      test_back_to_back();
      test_receiver_hold_off();
      req_if.valid <= 1'b0;
      while (frame_results_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/lpfp_pkg.sv
rtl/lpfp_if.sv
rtl/lpfp_ram.sv
rtl/lpfp_ctrl.sv
rtl/lpfp_datapath.sv
rtl/length_prefixed_frame_parser.sv
rtl/lpfp_checker.sv
tb/length_prefixed_frame_parser_test.sv
